[src/rv64i_instruction_decoder_unit_defines.svh]
// Assertion macros shared by the decoder RTL.
`ifndef RV64I_INSTRUCTION_DECODER_UNIT_DEFINES_SVH
`define RV64I_INSTRUCTION_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define RVDEC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rvdec assertion failed");
// Next-cycle implication, checked outside reset.
`define RVDEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rvdec assertion failed");
`else
`define RVDEC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RVDEC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[src/rvdec_pkg.sv]
package rvdec_pkg;

   // Major opcodes (instruction bits 6..0)
   localparam logic [6:0] OPC_SYSTEM = 7'h73;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_BRANCH = 7'h63;

   // funct3 codes
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [2:0] F3_SZ_B  = 3'd0;
   localparam logic [2:0] F3_SZ_H  = 3'd1;
   localparam logic [2:0] F3_SZ_W  = 3'd2;
   localparam logic [2:0] F3_SZ_D  = 3'd3;
   localparam logic [2:0] F3_SZ_BU = 3'd4;
   localparam logic [2:0] F3_SZ_HU = 3'd5;
   localparam logic [2:0] F3_SZ_WU = 3'd6;

   localparam logic [2:0] F3_PRIV  = 3'd0;
   localparam logic [2:0] F3_CSRRW = 3'd1;
   localparam logic [2:0] F3_CSRRS = 3'd2;
   localparam logic [2:0] F3_CSRRC = 3'd3;

   typedef enum logic [3:0] {
      ALU_ADD  = 4'd0,
      ALU_SUB  = 4'd1,
      ALU_SLL  = 4'd2,
      ALU_SLT  = 4'd3,
      ALU_SLTU = 4'd4,
      ALU_XOR  = 4'd5,
      ALU_SRL  = 4'd6,
      ALU_SRA  = 4'd7,
      ALU_OR   = 4'd8,
      ALU_AND  = 4'd9
   } alu_op_type;

   typedef enum logic [2:0] {
      WID_NONE   = 3'd0,
      WID_BYTE   = 3'd1,
      WID_HALF   = 3'd2,
      WID_WORD   = 3'd3,
      WID_DOUBLE = 3'd4
   } mem_width_type;

   typedef enum logic [2:0] {
      BR_NONE = 3'd0,
      BR_EQ   = 3'd1,
      BR_NE   = 3'd2,
      BR_LT   = 3'd3,
      BR_GE   = 3'd4,
      BR_LTU  = 3'd5,
      BR_GEU  = 3'd6
   } br_cond_type;

   typedef enum logic [1:0] {
      CSR_NONE = 2'd0,
      CSR_RW   = 2'd1,
      CSR_RS   = 2'd2,
      CSR_RC   = 2'd3
   } csr_op_type;

   // Control flags, msb first so that regwrite lands on bit 0
   typedef struct packed {
      logic csr;
      logic ecall;
      logic unsgn;
      logic auipc;
      logic jalr;
      logic jump;
      logic memwrite;
      logic memread;
      logic useimm;
      logic regwrite;
   } ctrl_flags_type;

   // Decoded instruction record
   typedef struct packed {
      logic [4:0]     dest_reg;
      logic [4:0]     src1_reg;
      logic [4:0]     src2_reg;
      logic [31:0]    imm_value;
      ctrl_flags_type flags;
      alu_op_type     alu_select;
      mem_width_type  access_width;
      br_cond_type    branch_kind;
      csr_op_type     csr_kind;
   } decoded_type;

endpackage

[src/rvdec_decode.sv]
module rvdec_decode (
   input  logic [31:0]          instr,
   output rvdec_pkg::decoded_type dec
);
   import rvdec_pkg::*;

   logic [6:0]  opcode;
   logic [2:0]  funct3;
   logic        bit30;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_u;
   logic [31:0] imm_j;
   alu_op_type  alu_reg;
   alu_op_type  alu_imm;

   assign opcode = instr[6:0];
   assign funct3 = instr[14:12];
   assign bit30  = instr[30];

   // Immediate formats; I, S, B and J sign-extended from bit 31, U zero-filled below
   assign imm_i = {{20{instr[31]}}, instr[31:20]};
   assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
   assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
   assign imm_u = {instr[31:12], 12'h000};
   assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};

   // ALU op from funct3; bit 30 picks sub only for register form, sra for both
   always_comb begin
      unique case (funct3)
         F3_ADD:  alu_imm = ALU_ADD;
         F3_SLL:  alu_imm = ALU_SLL;
         F3_SLT:  alu_imm = ALU_SLT;
         F3_SLTU: alu_imm = ALU_SLTU;
         F3_XOR:  alu_imm = ALU_XOR;
         F3_SR:   alu_imm = bit30 ? ALU_SRA : ALU_SRL;
         F3_OR:   alu_imm = ALU_OR;
         default: alu_imm = ALU_AND;
      endcase
      alu_reg = (funct3 == F3_ADD && bit30) ? ALU_SUB : alu_imm;
   end

   // Main decode
   always_comb begin
      dec              = '0;
      dec.dest_reg     = instr[11:7];
      dec.src1_reg     = instr[19:15];
      dec.src2_reg     = instr[24:20];
      dec.alu_select   = ALU_ADD;
      dec.access_width = WID_NONE;
      dec.branch_kind  = BR_NONE;
      dec.csr_kind     = CSR_NONE;

      unique case (opcode)
         OPC_SYSTEM: begin
            if (funct3 == F3_PRIV) begin
               dec.flags.ecall = 1'b1;
            end else begin
               dec.flags.csr = 1'b1;
               dec.imm_value = imm_i;
               case (funct3)
                  F3_CSRRW: dec.csr_kind = CSR_RW;
                  F3_CSRRS: dec.csr_kind = CSR_RS;
                  F3_CSRRC: dec.csr_kind = CSR_RC;
                  default:  dec.csr_kind = CSR_NONE;
               endcase
            end
         end
         OPC_OP: begin
            dec.flags.regwrite = 1'b1;
            dec.alu_select     = alu_reg;
         end
         OPC_OP_IMM: begin
            dec.flags.regwrite = 1'b1;
            dec.flags.useimm   = 1'b1;
            dec.imm_value      = imm_i;
            dec.alu_select     = alu_imm;
         end
         OPC_LOAD: begin
            dec.flags.regwrite = 1'b1;
            dec.flags.useimm   = 1'b1;
            dec.flags.memread  = 1'b1;
            dec.imm_value      = imm_i;
            dec.flags.unsgn    = funct3 inside {F3_SZ_BU, F3_SZ_HU, F3_SZ_WU};
            case (funct3)
               F3_SZ_B, F3_SZ_BU: dec.access_width = WID_BYTE;
               F3_SZ_H, F3_SZ_HU: dec.access_width = WID_HALF;
               F3_SZ_W, F3_SZ_WU: dec.access_width = WID_WORD;
               F3_SZ_D:           dec.access_width = WID_DOUBLE;
               default:           dec.access_width = WID_NONE;
            endcase
         end
         OPC_STORE: begin
            dec.flags.memwrite = 1'b1;
            dec.flags.useimm   = 1'b1;
            dec.imm_value      = imm_s;
            case (funct3)
               F3_SZ_B: dec.access_width = WID_BYTE;
               F3_SZ_H: dec.access_width = WID_HALF;
               F3_SZ_W: dec.access_width = WID_WORD;
               F3_SZ_D: dec.access_width = WID_DOUBLE;
               default: dec.access_width = WID_NONE;
            endcase
         end
         OPC_JAL: begin
            dec.flags.regwrite = 1'b1;
            dec.flags.useimm   = 1'b1;
            dec.flags.jump     = 1'b1;
            dec.imm_value      = imm_j;
         end
         OPC_JALR: begin
            dec.flags.regwrite = 1'b1;
            dec.flags.useimm   = 1'b1;
            dec.flags.jump     = 1'b1;
            dec.flags.jalr     = 1'b1;
            dec.imm_value      = imm_i;
         end
         OPC_LUI: begin
            dec.flags.regwrite = 1'b1;
            dec.flags.useimm   = 1'b1;
            dec.imm_value      = imm_u;
            dec.src1_reg       = 5'd0;
         end
         OPC_AUIPC: begin
            dec.flags.regwrite = 1'b1;
            dec.flags.useimm   = 1'b1;
            dec.flags.auipc    = 1'b1;
            dec.imm_value      = imm_u;
         end
         OPC_BRANCH: begin
            dec.imm_value = imm_b;
            case (funct3)
               F3_BEQ:  dec.branch_kind = BR_EQ;
               F3_BNE:  dec.branch_kind = BR_NE;
               F3_BLT:  dec.branch_kind = BR_LT;
               F3_BGE:  dec.branch_kind = BR_GE;
               F3_BLTU: dec.branch_kind = BR_LTU;
               F3_BGEU: dec.branch_kind = BR_GEU;
               default: dec.branch_kind = BR_NONE;
            endcase
         end
         default: begin
            // unknown opcode: control stays zero
         end
      endcase
   end

endmodule

[src/rv64i_instruction_decoder_unit.sv]
// Path: a request is accepted into the input register, decoded, and taken into the
//   result register, where rsp_valid marks it until the receiver takes it.
// Throughput: one instruction per cycle; a full result register that is not
//   taken stalls the input register, which then holds req_ready low.
// Reset: synchronous, active high; clears both stage valid bits, no clearing pass.
`include "rv64i_instruction_decoder_unit_defines.svh"

module rv64i_instruction_decoder_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_instruction_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_dest_reg,
   output logic [4:0]         rsp_src1_reg,
   output logic [4:0]         rsp_src2_reg,
   output logic signed [31:0] rsp_imm_value,
   output logic [9:0]         rsp_control_flags,
   output logic [3:0]         rsp_alu_select,
   output logic [2:0]         rsp_access_width,
   output logic [2:0]         rsp_branch_kind,
   output logic [1:0]         rsp_csr_kind
);
   import rvdec_pkg::*;

   logic        in_vld_ff;
   logic        in_vld_in;
   logic [31:0] in_word_ff;
   logic        out_vld_ff;
   logic        out_vld_in;
   decoded_type out_ff;
   decoded_type dec;
   logic        out_free;
   logic        advance;

   // Stage handshake: output slot frees when empty or being taken
   assign out_free  = !out_vld_ff || rsp_ready;
   assign advance   = in_vld_ff && out_free;
   assign req_ready = !in_vld_ff || out_free;

   assign in_vld_in  = (req_valid && req_ready) || (in_vld_ff && !out_free);
   assign out_vld_in = advance || (out_vld_ff && !rsp_ready);

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_instruction_word;
      end
      if (advance) begin
         out_ff <= dec;
      end
   end

   rvdec_decode u_decode (
      .instr (in_word_ff),
      .dec   (dec)
   );

   // Result transaction
   assign rsp_valid         = out_vld_ff;
   assign rsp_dest_reg      = out_ff.dest_reg;
   assign rsp_src1_reg      = out_ff.src1_reg;
   assign rsp_src2_reg      = out_ff.src2_reg;
   assign rsp_imm_value     = out_ff.imm_value;
   assign rsp_control_flags = out_ff.flags;
   assign rsp_alu_select    = out_ff.alu_select;
   assign rsp_access_width  = out_ff.access_width;
   assign rsp_branch_kind   = out_ff.branch_kind;
   assign rsp_csr_kind      = out_ff.csr_kind;

   // Checks
   `RVDEC_ASSERT_NEXT(a_advance_fills_out, clock, reset, advance, out_vld_ff)
   `RVDEC_ASSERT_IMPL(a_stall_only_when_full, clock, reset, !req_ready, in_vld_ff && out_vld_ff)
   `RVDEC_ASSERT_IMPL(a_lui_src1_zero, clock, reset, in_word_ff[6:0] == OPC_LUI, dec.src1_reg == 5'd0)
   `RVDEC_ASSERT_NEXT(a_held_out_stable, clock, reset, out_vld_ff && !rsp_ready, $stable(out_ff))

endmodule

[tb/rv64i_instruction_decoder_unit_tb.sv]
`timescale 1ns / 100ps

module rv64i_instruction_decoder_unit_tb;
   import rvdec_pkg::*;

   // funct3 codes that the package does not name
   localparam logic [2:0] F3_JALR        = 3'd0;
   localparam logic [2:0] F3_LOAD_RSVD   = 3'd7;
   localparam logic [2:0] F3_STORE_RSVD  = 3'd4;
   localparam logic [2:0] F3_BRANCH_RSVD = 3'd2;
   localparam logic [2:0] F3_CSRRWI      = 3'd5;

   // W-form opcodes, not decoded by this block
   localparam logic [6:0] OPC_OP_32     = 7'h3B;
   localparam logic [6:0] OPC_OP_IMM_32 = 7'h1B;

   localparam logic [6:0] FUNCT7_BASE = 7'h00;
   localparam logic [6:0] FUNCT7_ALT  = 7'h20;

   localparam int RANDOM_PER_PHASE = 463;
   localparam int DRAIN_GUARD      = 2000;

   typedef struct {
      logic [31:0] word;
      logic        pinned;
      decoded_type rec;
   } stim_row_type;

   typedef struct {
      logic [31:0] word;
      decoded_type rec;
   } pending_decode_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_instruction_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_dest_reg;
   logic [4:0]  rsp_src1_reg;
   logic [4:0]  rsp_src2_reg;
   logic signed [31:0] rsp_imm_value;
   logic [9:0]  rsp_control_flags;
   logic [3:0]  rsp_alu_select;
   logic [2:0]  rsp_access_width;
   logic [2:0]  rsp_branch_kind;
   logic [1:0]  rsp_csr_kind;

   // hand-typed expectation travels with the transaction
   logic        pinned_valid = 1'b0;
   decoded_type pinned_rec = '0;

   int idle_pct  = 0;
   int stall_pct = 0;
   int sent_count = 0;
   int checked_count = 0;
   int mismatch_count = 0;

   stim_row_type       stim_rows[$];
   pending_decode_type expected_decodes[$];

   rv64i_instruction_decoder_unit uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_instruction_word (req_instruction_word),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_dest_reg         (rsp_dest_reg),
      .rsp_src1_reg         (rsp_src1_reg),
      .rsp_src2_reg         (rsp_src2_reg),
      .rsp_imm_value        (rsp_imm_value),
      .rsp_control_flags    (rsp_control_flags),
      .rsp_alu_select       (rsp_alu_select),
      .rsp_access_width     (rsp_access_width),
      .rsp_branch_kind      (rsp_branch_kind),
      .rsp_csr_kind         (rsp_csr_kind)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [31:0] enc(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                       logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
      return {f7, rs2, rs1, f3, rd, op};
   endfunction

   // register fields only, every control output cleared
   function automatic decoded_type regs_only(logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2);
      decoded_type d;
      d = '0;
      d.dest_reg = rd;
      d.src1_reg = rs1;
      d.src2_reg = rs2;
      return d;
   endfunction

   function automatic logic [31:0] imm_i(logic [31:0] w);
      return {{20{w[31]}}, w[31:20]};
   endfunction

   function automatic alu_op_type alu_for(logic [31:0] w, logic reg_form);
      case (w[14:12])
         F3_ADD:  return (reg_form && w[30]) ? ALU_SUB : ALU_ADD;
         F3_SLL:  return ALU_SLL;
         F3_SLT:  return ALU_SLT;
         F3_SLTU: return ALU_SLTU;
         F3_XOR:  return ALU_XOR;
         F3_SR:   return w[30] ? ALU_SRA : ALU_SRL;
         F3_OR:   return ALU_OR;
         default: return ALU_AND;
      endcase
   endfunction

   // decoded form of one instruction word
   function automatic decoded_type decode_word(logic [31:0] w);
      decoded_type d;
      logic [2:0]  f3;
      f3 = w[14:12];
      d = regs_only(w[11:7], w[19:15], w[24:20]);
      case (w[6:0])
         OPC_SYSTEM: begin
            if (f3 == F3_PRIV) begin
               d.flags.ecall = 1'b1;
            end else begin
               d.flags.csr = 1'b1;
               d.imm_value = imm_i(w);
               case (f3)
                  F3_CSRRW: d.csr_kind = CSR_RW;
                  F3_CSRRS: d.csr_kind = CSR_RS;
                  F3_CSRRC: d.csr_kind = CSR_RC;
                  default:  d.csr_kind = CSR_NONE;
               endcase
            end
         end
         OPC_OP: begin
            d.flags.regwrite = 1'b1;
            d.alu_select = alu_for(w, 1'b1);
         end
         OPC_OP_IMM: begin
            d.flags.regwrite = 1'b1;
            d.flags.useimm = 1'b1;
            d.imm_value = imm_i(w);
            d.alu_select = alu_for(w, 1'b0);
         end
         OPC_LOAD: begin
            d.flags.regwrite = 1'b1;
            d.flags.useimm = 1'b1;
            d.flags.memread = 1'b1;
            d.imm_value = imm_i(w);
            d.flags.unsgn = (f3 == F3_SZ_BU || f3 == F3_SZ_HU || f3 == F3_SZ_WU);
            case (f3)
               F3_SZ_B, F3_SZ_BU: d.access_width = WID_BYTE;
               F3_SZ_H, F3_SZ_HU: d.access_width = WID_HALF;
               F3_SZ_W, F3_SZ_WU: d.access_width = WID_WORD;
               F3_SZ_D:           d.access_width = WID_DOUBLE;
               default:           d.access_width = WID_NONE;
            endcase
         end
         OPC_STORE: begin
            d.flags.memwrite = 1'b1;
            d.flags.useimm = 1'b1;
            d.imm_value = {{20{w[31]}}, w[31:25], w[11:7]};
            case (f3)
               F3_SZ_B: d.access_width = WID_BYTE;
               F3_SZ_H: d.access_width = WID_HALF;
               F3_SZ_W: d.access_width = WID_WORD;
               F3_SZ_D: d.access_width = WID_DOUBLE;
               default: d.access_width = WID_NONE;
            endcase
         end
         OPC_JAL: begin
            d.flags.regwrite = 1'b1;
            d.flags.useimm = 1'b1;
            d.flags.jump = 1'b1;
            d.imm_value = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
         end
         OPC_JALR: begin
            d.flags.regwrite = 1'b1;
            d.flags.useimm = 1'b1;
            d.flags.jump = 1'b1;
            d.flags.jalr = 1'b1;
            d.imm_value = imm_i(w);
         end
         OPC_LUI: begin
            d.flags.regwrite = 1'b1;
            d.flags.useimm = 1'b1;
            d.imm_value = {w[31:12], 12'h000};
            d.src1_reg = '0;
         end
         OPC_AUIPC: begin
            d.flags.regwrite = 1'b1;
            d.flags.useimm = 1'b1;
            d.flags.auipc = 1'b1;
            d.imm_value = {w[31:12], 12'h000};
         end
         OPC_BRANCH: begin
            d.imm_value = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            case (f3)
               F3_BEQ:  d.branch_kind = BR_EQ;
               F3_BNE:  d.branch_kind = BR_NE;
               F3_BLT:  d.branch_kind = BR_LT;
               F3_BGE:  d.branch_kind = BR_GE;
               F3_BLTU: d.branch_kind = BR_LTU;
               F3_BGEU: d.branch_kind = BR_GEU;
               default: d.branch_kind = BR_NONE;
            endcase
         end
         default: ;
      endcase
      return d;
   endfunction

   function automatic void add_row(logic [31:0] w, logic pin, decoded_type rec);
      stim_rows.push_back(stim_row_type'{w, pin, rec});
   endfunction

   // mostly well-formed opcodes with random bodies, some W-forms and raw noise
   function automatic logic [31:0] random_word();
      logic [31:0] w;
      int          pick;
      w = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
         case ($urandom_range(0, 9))
            0: w[6:0] = OPC_SYSTEM;
            1: w[6:0] = OPC_OP;
            2: w[6:0] = OPC_OP_IMM;
            3: w[6:0] = OPC_LOAD;
            4: w[6:0] = OPC_STORE;
            5: w[6:0] = OPC_JAL;
            6: w[6:0] = OPC_JALR;
            7: w[6:0] = OPC_LUI;
            8: w[6:0] = OPC_AUIPC;
            default: w[6:0] = OPC_BRANCH;
         endcase
         if ((w[6:0] == OPC_OP || w[6:0] == OPC_OP_IMM) && $urandom_range(0, 1) == 1)
            w[31:25] = ($urandom_range(0, 1) == 1) ? FUNCT7_ALT : FUNCT7_BASE;
      end else if (pick < 90) begin
         w[6:0] = ($urandom_range(0, 1) == 1) ? OPC_OP_32 : OPC_OP_IMM_32;
      end
      return w;
   endfunction

   // one transaction on the request channel
   task automatic send_word(logic [31:0] w, logic pin, decoded_type rec);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_instruction_word <= w;
      pinned_valid <= pin;
      pinned_rec <= rec;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // hold the request side quiet until every decode is back
   task automatic drain_results();
      int guard;
      req_valid <= 1'b0;
      @(posedge clock);
      for (guard = 0; guard < DRAIN_GUARD && expected_decodes.size() != 0; guard++)
         @(posedge clock);
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // scoreboard: predict on request, compare on response
   always @(posedge clock) begin
      pending_decode_type exp;
      logic               bad;
      if (!reset) begin
         if (req_valid && req_ready) begin
            exp.word = req_instruction_word;
            exp.rec = pinned_valid ? pinned_rec : decode_word(req_instruction_word);
            expected_decodes.push_back(exp);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_decodes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: rd=%0d rs1=%0d rs2=%0d imm=%h flags=%h",
                           rsp_dest_reg, rsp_src1_reg, rsp_src2_reg, rsp_imm_value,
                           rsp_control_flags);
            end else begin
               exp = expected_decodes.pop_front();
               checked_count++;
               bad = (rsp_dest_reg !== exp.rec.dest_reg) ||
                     (rsp_src1_reg !== exp.rec.src1_reg) ||
                     (rsp_src2_reg !== exp.rec.src2_reg) ||
                     (rsp_imm_value !== exp.rec.imm_value) ||
                     (rsp_control_flags !== exp.rec.flags) ||
                     (rsp_alu_select !== exp.rec.alu_select) ||
                     (rsp_access_width !== exp.rec.access_width) ||
                     (rsp_branch_kind !== exp.rec.branch_kind) ||
                     (rsp_csr_kind !== exp.rec.csr_kind);
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch on %h: exp rd=%0d rs1=%0d rs2=%0d imm=%h fl=%h alu=%0d",
                              exp.word, exp.rec.dest_reg, exp.rec.src1_reg, exp.rec.src2_reg,
                              exp.rec.imm_value, exp.rec.flags, exp.rec.alu_select);
                     $display("   exp wid=%0d br=%0d csr=%0d | got rd=%0d rs1=%0d rs2=%0d",
                              exp.rec.access_width, exp.rec.branch_kind, exp.rec.csr_kind,
                              rsp_dest_reg, rsp_src1_reg, rsp_src2_reg);
                     $display("   got imm=%h fl=%h alu=%0d wid=%0d br=%0d csr=%0d",
                              rsp_imm_value, rsp_control_flags, rsp_alu_select,
                              rsp_access_width, rsp_branch_kind, rsp_csr_kind);
                  end
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      decoded_type r;
      decoded_type blank;
      int          i;
      int          ph;
      int          leftover;

      blank = '0;

      // hand-checked rows: all-zero and all-one words, ecall/ebreak, LUI, W-form
      add_row(32'h0000_0000, 1'b1, regs_only(5'd0, 5'd0, 5'd0));
      add_row(32'hFFFF_FFFF, 1'b1, regs_only(5'd31, 5'd31, 5'd31));
      r = regs_only(5'd0, 5'd0, 5'd0);
      r.flags.ecall = 1'b1;
      add_row(32'h0000_0073, 1'b1, r);
      r = regs_only(5'd0, 5'd0, 5'd1);
      r.flags.ecall = 1'b1;
      add_row(32'h0010_0073, 1'b1, r);
      r = regs_only(5'd1, 5'd0, 5'd31);
      r.imm_value = 32'hFFFF_F000;
      r.flags.regwrite = 1'b1;
      r.flags.useimm = 1'b1;
      add_row(32'hFFFF_F0B7, 1'b1, r);
      add_row(32'hFFFF_FFBB, 1'b1, regs_only(5'd31, 5'd31, 5'd31));

      // every ALU operation, register and immediate forms
      add_row(enc(FUNCT7_ALT, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_OP), 1'b0, blank);
      add_row(enc(FUNCT7_BASE, 5'd5, 5'd6, F3_SLT, 5'd7, OPC_OP), 1'b0, blank);
      add_row(enc(FUNCT7_BASE, 5'd8, 5'd9, F3_XOR, 5'd10, OPC_OP), 1'b0, blank);
      add_row(enc(FUNCT7_ALT, 5'd11, 5'd12, F3_OR, 5'd13, OPC_OP), 1'b0, blank);
      add_row(enc(7'h7F, 5'd31, 5'd1, F3_ADD, 5'd1, OPC_OP_IMM), 1'b0, blank);
      add_row(enc(FUNCT7_BASE, 5'd31, 5'd2, F3_SLL, 5'd3, OPC_OP_IMM), 1'b0, blank);
      add_row(enc(7'h40, 5'd0, 5'd4, F3_SLTU, 5'd5, OPC_OP_IMM), 1'b0, blank);
      add_row(enc(FUNCT7_BASE, 5'd7, 5'd14, F3_SR, 5'd15, OPC_OP_IMM), 1'b0, blank);
      add_row(enc(FUNCT7_ALT, 5'd7, 5'd16, F3_SR, 5'd17, OPC_OP_IMM), 1'b0, blank);
      add_row(enc(7'h3F, 5'd31, 5'd18, F3_AND, 5'd19, OPC_OP_IMM), 1'b0, blank);

      // memory, with the reserved widths
      add_row(enc(7'h40, 5'd0, 5'd1, F3_SZ_HU, 5'd2, OPC_LOAD), 1'b0, blank);
      add_row(enc(7'h7F, 5'd31, 5'd3, F3_LOAD_RSVD, 5'd4, OPC_LOAD), 1'b0, blank);
      add_row(enc(7'h7F, 5'd5, 5'd6, F3_SZ_D, 5'd31, OPC_STORE), 1'b0, blank);
      add_row(enc(7'h40, 5'd7, 5'd8, F3_STORE_RSVD, 5'd0, OPC_STORE), 1'b0, blank);

      // branches at the most negative and at a positive immediate, plus a reserved condition
      add_row(enc(7'h40, 5'd1, 5'd2, F3_BGEU, 5'd0, OPC_BRANCH), 1'b0, blank);
      add_row(enc(7'h3F, 5'd3, 5'd4, F3_BNE, 5'd30, OPC_BRANCH), 1'b0, blank);
      add_row(enc(7'h2A, 5'd9, 5'd10, F3_BRANCH_RSVD, 5'd11, OPC_BRANCH), 1'b0, blank);

      // jumps, AUIPC and CSR access
      add_row(32'h8000_006F, 1'b0, blank);
      add_row(enc(7'h7F, 5'd31, 5'd1, F3_JALR, 5'd1, OPC_JALR), 1'b0, blank);
      add_row(32'h8000_0017, 1'b0, blank);
      add_row(enc(7'h7F, 5'd31, 5'd3, F3_CSRRC, 5'd4, OPC_SYSTEM), 1'b0, blank);
      add_row(enc(7'h00, 5'd1, 5'd5, F3_CSRRWI, 5'd6, OPC_SYSTEM), 1'b0, blank);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, no idling
      for (i = 0; i < stim_rows.size(); i++)
         send_word(stim_rows[i].word, stim_rows[i].pinned, stim_rows[i].rec);
      drain_results();

      // random traffic under four idle/stall mixes, draining between them
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 54; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 54; end
            default: begin idle_pct = 31; stall_pct = 31; end
         endcase
         for (i = 0; i < RANDOM_PER_PHASE; i++)
            send_word(random_word(), 1'b0, blank);
         drain_results();
      end

      stall_pct = 0;
      repeat (8) @(posedge clock);

      leftover = expected_decodes.size();
      if (leftover != 0)
         $display("%0d decodes never came back", leftover);
      $display("sent %0d instruction words (%0d directed), compared %0d decodes,",
               sent_count, stim_rows.size(), checked_count);
      $display("over free-running, sender-idle, receiver-stall and mixed traffic");
      if (mismatch_count == 0 && leftover == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
